[hw/rtl/hla_pkg.sv]
// Shared types, constants and the fixed trig table for the Hough line accumulator.
// No dependencies; every other file of the block imports this package.
package hla_pkg;

    // Angle grid and fixed-point layout
    localparam int THETA_STEPS   = 180;
    localparam int THETA_W       = 8;
    localparam int TRIG_W        = 16;   // Q2.14 signed
    localparam int FRAC_BITS     = 14;
    localparam int DELTA_W       = 11;   // signed pixel offset from the centre
    localparam int PROD_W        = DELTA_W + TRIG_W;
    localparam int SUM_W         = 29;
    localparam int HI_W          = SUM_W - FRAC_BITS;
    localparam int ROUND_HALF    = 8192;

    // Field widths of the stream items
    localparam int KIND_W        = 2;
    localparam int PIX_W         = 10;
    localparam int VALUE_W       = 8;
    localparam int RHO_IDX_W     = 11;

    // Configuration registers
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 25;
    localparam int DIM_W         = 11;
    localparam int OFFSET_W      = 25;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RHO_OFFSET   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_LEVEL   = 2'd3;
    localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = 11'd1024;
    localparam logic [OFFSET_W-1:0] RHO_OFFSET_RST   = 25'd11863283;
    localparam logic [VALUE_W-1:0]  EDGE_LEVEL_RST   = 8'd250;

    // Item kinds on the input stream
    localparam logic [KIND_W-1:0] KIND_VOTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Default sizes
    localparam int RHO_BINS_DEF   = 2048;
    localparam int COUNT_BITS_DEF = 21;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_VOTE      = 2'd0,
        OP_READ      = 2'd1,
        OP_READ_ZERO = 2'd2,
        OP_CLEAR     = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                  op;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [RHO_IDX_W-1:0]     rho_idx;
        logic [THETA_W-1:0]       theta_idx;
    } cmd_t;

    // Trig table: cos in the high half, sin in the low half, Q2.14
    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam int          SERIES_TERMS = 12;
    // series term divisors (2n)(2n+1) for n = 1..SERIES_TERMS
    localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic [2*TRIG_W-1:0] trig_rom_t [THETA_STEPS];

    // round(16384 * sin(k deg)) from a Q30 Taylor series, k in 0..90
    function automatic logic [TRIG_W-1:0] sine_q14(input logic [6:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x    = (64'(k) * PI_Q30) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = '0;
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            if ((n % 2) == 1)
                sum = sum + $signed(term);
            else
                sum = sum - $signed(term);
            term = ((term * x2) >> 30) / SERIES_DIV[n - 1];
        end
        if (sum < 0)
            sum = '0;
        rnd = ($unsigned(sum) + 64'd32768) >> 16;
        return rnd[TRIG_W-1:0];
    endfunction

    function automatic trig_rom_t build_trig();
        trig_rom_t         rom;
        logic [TRIG_W-1:0] c;
        logic [TRIG_W-1:0] s;
        for (int t = 0; t < THETA_STEPS; t++) begin
            if (t <= 90) begin
                c = sine_q14(7'(90 - t));
                s = sine_q14(7'(t));
            end else begin
                c = TRIG_W'(0) - sine_q14(7'(t - 90));
                s = sine_q14(7'(180 - t));
            end
            rom[t] = {c, s};
        end
        return rom;
    endfunction

    localparam trig_rom_t TRIG_ROM = build_trig();

endpackage

[hw/rtl/hla_front.sv]
// Front end: takes input items, decodes the kind and turns each kept item into a queue command.
// Depends on hla_pkg; feeds hla_cmd_fifo.
module hla_front #(
    parameter int RHO_BINS = hla_pkg::RHO_BINS_DEF
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,
    input  logic [hla_pkg::KIND_W-1:0]    s_tuser,
    input  logic [hla_pkg::DIM_W-1:0]     image_width,
    input  logic [hla_pkg::DIM_W-1:0]     image_height,
    input  logic [hla_pkg::VALUE_W-1:0]   edge_level,
    input  logic                          q_full,
    input  logic                          clearing,
    output logic                          q_push,
    output hla_pkg::cmd_t                 q_cmd
);
    import hla_pkg::*;

    logic [PIX_W-1:0]     pixel_x;
    logic [PIX_W-1:0]     pixel_y;
    logic [VALUE_W-1:0]   pixel_value;
    logic [THETA_W-1:0]   theta_index;
    logic [RHO_IDX_W-1:0] rho_index;
    logic                 accept;
    logic                 keep;
    logic                 read_in_range;

    assign pixel_x     = s_tdata[9:0];
    assign pixel_y     = s_tdata[19:10];
    assign pixel_value = s_tdata[27:20];
    assign theta_index = s_tdata[35:28];
    assign rho_index   = s_tdata[46:36];

    // no intake during a clearing pass
    assign s_tready = !q_full && !clearing;
    assign accept   = s_tvalid && s_tready;

    assign read_in_range = (32'(theta_index) < 32'(THETA_STEPS))
                        && (32'(rho_index) < 32'(RHO_BINS));

    always_comb
    begin
        q_cmd.dx        = $signed({1'b0, pixel_x}) - $signed({1'b0, image_width[DIM_W-1:1]});
        q_cmd.dy        = $signed({1'b0, pixel_y}) - $signed({1'b0, image_height[DIM_W-1:1]});
        q_cmd.rho_idx   = rho_index;
        q_cmd.theta_idx = theta_index;
        q_cmd.op        = OP_VOTE;
        keep            = 1'b0;
        case (s_tuser)
            KIND_VOTE:
            begin
                q_cmd.op = OP_VOTE;
                keep     = pixel_value > edge_level;
            end
            KIND_READ:
            begin
                q_cmd.op = read_in_range ? OP_READ : OP_READ_ZERO;
                keep     = 1'b1;
            end
            KIND_CLEAR:
            begin
                q_cmd.op = OP_CLEAR;
                keep     = 1'b1;
            end
            default:
            begin
                q_cmd.op = OP_VOTE;
                keep     = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

endmodule

[hw/rtl/hla_cmd_fifo.sv]
// Short command queue that decouples the front end from the vote engine.
// Depends on hla_pkg for the command type and depth.
module hla_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hla_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output hla_pkg::cmd_t  head_cmd
);
    import hla_pkg::*;

    cmd_t               q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = count_reg == Q_CNT_W'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

[hw/rtl/hla_back.sv]
// Vote engine: angle sequencer, rho pipeline, bin memory with read-modify-write,
// clearing sweep and result register. Depends on hla_pkg (types, trig table).
module hla_back #(
    parameter int RHO_BINS   = hla_pkg::RHO_BINS_DEF,
    parameter int COUNT_BITS = hla_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hla_pkg::OFFSET_W-1:0]  rho_offset,
    input  logic                          q_valid,
    input  hla_pkg::cmd_t                 q_head,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COUNT_BITS-1:0]         out_data
);
    import hla_pkg::*;

    localparam int DEPTH  = RHO_BINS * THETA_STEPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RHO_W  = $clog2(RHO_BINS);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [THETA_W-1:0]    LAST_T    = THETA_W'(THETA_STEPS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_VOTE  = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_CLEAR = 4'b1000
    } back_state_t;

    back_state_t        state_reg;
    back_state_t        state_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [THETA_W-1:0] t_reg;
    logic [THETA_W-1:0] t_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;

    // pipeline: A trig fetch, B products, C rho, D address, E memory data
    logic                      a_valid_reg;
    logic [THETA_W-1:0]        a_t_reg;
    logic signed [TRIG_W-1:0]  a_cos_reg;
    logic signed [TRIG_W-1:0]  a_sin_reg;
    logic signed [DELTA_W-1:0] a_dx_reg;
    logic signed [DELTA_W-1:0] a_dy_reg;
    logic                      b_valid_reg;
    logic [THETA_W-1:0]        b_t_reg;
    logic signed [PROD_W-1:0]  b_pc_reg;
    logic signed [PROD_W-1:0]  b_ps_reg;
    logic                      c_valid_reg;
    logic [THETA_W-1:0]        c_t_reg;
    logic [RHO_W-1:0]          c_rho_reg;
    logic                      d_valid_reg;
    logic [ADDR_W-1:0]         d_addr_reg;
    logic                      e_vote_reg;
    logic                      e_read_reg;
    logic [ADDR_W-1:0]         e_addr_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [COUNT_BITS-1:0]     out_data_reg;

    logic [COUNT_BITS-1:0]     bins_mem [DEPTH];
    logic [COUNT_BITS-1:0]     rd_data_reg;

    logic                      issue_a;
    logic                      rd_issue;
    logic                      zero_load;
    logic                      pipe_empty;
    logic [2*TRIG_W-1:0]       trig_word;
    logic signed [SUM_W-1:0]   v_sum;
    logic signed [SUM_W-1:0]   w_sum;
    logic [HI_W-1:0]           rho_hi;
    logic                      rho_ok;
    logic [ADDR_W-1:0]         read_addr;
    logic [ADDR_W-1:0]         mem_raddr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0]     mem_wdata;
    logic [COUNT_BITS-1:0]     bin_inc;

    assign pipe_empty = !a_valid_reg && !b_valid_reg && !c_valid_reg
                     && !d_valid_reg && !e_vote_reg && !e_read_reg;
    assign clearing   = state_reg == ST_CLEAR;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        t_next        = t_reg;
        clr_addr_next = clr_addr_reg;
        q_pop         = 1'b0;
        issue_a       = 1'b0;
        rd_issue      = 1'b0;
        zero_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    if (q_head.op == OP_VOTE)
                    begin
                        state_next = ST_VOTE;
                        t_next     = '0;
                    end
                    else
                        state_next = ST_WAIT;
                end
            end
            ST_VOTE:
            begin
                issue_a = 1'b1;
                if (t_reg == LAST_T)
                    state_next = ST_IDLE;
                else
                    t_next = t_reg + 1'b1;
            end
            ST_WAIT:
            begin
                // reads and clears wait until every pending write has landed
                if (pipe_empty)
                begin
                    if (cmd_reg.op == OP_CLEAR)
                    begin
                        state_next    = ST_CLEAR;
                        clr_addr_next = '0;
                    end
                    else if (!out_valid_reg)
                    begin
                        rd_issue   = cmd_reg.op == OP_READ;
                        zero_load  = cmd_reg.op == OP_READ_ZERO;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
                else
                    clr_addr_next = clr_addr_reg + 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            t_reg         <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_vote_reg    <= 1'b0;
            e_read_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            t_reg         <= t_next;
            a_valid_reg   <= issue_a;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg && rho_ok;
            d_valid_reg   <= c_valid_reg;
            e_vote_reg    <= d_valid_reg;
            e_read_reg    <= rd_issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // rho = round(dx*cos + dy*sin + offset), halves away from zero
    assign trig_word = TRIG_ROM[t_reg];
    assign v_sum = SUM_W'(b_pc_reg) + SUM_W'(b_ps_reg)
                 + SUM_W'($signed({1'b0, rho_offset}));
    assign w_sum = v_sum + SUM_W'(ROUND_HALF);
    assign rho_hi = w_sum[SUM_W-1:FRAC_BITS];
    // negative sums only survive when they round to zero
    assign rho_ok = v_sum[SUM_W-1] ? (!w_sum[SUM_W-1] && (w_sum != '0))
                                   : (rho_hi < HI_W'(RHO_BINS));

    assign read_addr = ADDR_W'(ADDR_W'(cmd_reg.rho_idx) * ADDR_W'(THETA_STEPS))
                     + ADDR_W'(cmd_reg.theta_idx);

    always_ff @(posedge clk)
    begin
        a_t_reg   <= t_reg;
        a_cos_reg <= trig_word[2*TRIG_W-1:TRIG_W];
        a_sin_reg <= trig_word[TRIG_W-1:0];
        a_dx_reg  <= cmd_reg.dx;
        a_dy_reg  <= cmd_reg.dy;
        cmd_reg   <= cmd_next;

        b_t_reg   <= a_t_reg;
        b_pc_reg  <= PROD_W'(a_dx_reg) * PROD_W'(a_cos_reg);
        b_ps_reg  <= PROD_W'(a_dy_reg) * PROD_W'(a_sin_reg);

        c_t_reg   <= b_t_reg;
        c_rho_reg <= v_sum[SUM_W-1] ? '0 : rho_hi[RHO_W-1:0];

        d_addr_reg <= ADDR_W'(ADDR_W'(c_rho_reg) * ADDR_W'(THETA_STEPS))
                    + ADDR_W'(c_t_reg);
        e_addr_reg <= d_addr_reg;

        if (e_read_reg)
            out_data_reg <= rd_data_reg;
        else if (zero_load)
            out_data_reg <= '0;
    end

    // bin memory: one write, one registered read per cycle
    assign mem_raddr = d_valid_reg ? d_addr_reg : read_addr;
    assign bin_inc   = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = e_vote_reg;
            mem_waddr = e_addr_reg;
            mem_wdata = bin_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bins_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= bins_mem[mem_raddr];
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (e_read_reg || zero_load)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // sweep never overlaps an update in flight
    a_clear_no_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!e_vote_reg && !d_valid_reg && !e_read_reg))
        else $error("clearing sweep overlaps a pending bin update");

    // a read only lands in an empty result register
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        e_read_reg |-> !out_valid_reg)
        else $error("bin read returned into a full result register");

    // vote updates stay inside the bin memory
    a_vote_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        e_vote_reg |-> (e_addr_reg <= LAST_ADDR))
        else $error("vote address beyond the bin memory");

    // last angle ends the vote sequence
    a_vote_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VOTE && t_reg == LAST_T) |=> (state_reg == ST_IDLE))
        else $error("angle sequence did not end after the last angle");

endmodule

[hw/rtl/hough_line_accumulator_core.sv]
// Hough line accumulator top level: configuration registers and the
// front end / command queue / vote engine chain. Depends on hla_pkg.
//
// Usage:
//   s_* stream: one item per handshake. s_tuser is the kind (vote, read, clear);
//   s_tdata carries pixel position and value for a vote, or angle and distance
//   for a read. m_* stream: one item (bin count) per read item, nothing else.
//   cfg_we/cfg_index/cfg_data: write-only registers, written while idle.
// Engine use: a voting pixel holds the vote engine for its pop from the queue
//   plus one bin read-modify-write per angle on the bin memory. Pixels at or
//   below the edge level and unused kinds cost no engine time. A read waits
//   for the update pipeline to drain and the result register to be free, then
//   returns its count through the memory read register and the result
//   register; a read outside the bin grid returns 0.
// Clear: drains, then sweeps all RHO_BINS * 180 bin entries (368640 by default),
//   one entry per cycle. The same sweep runs after reset; s_tready stays low
//   while a sweep runs.
// Stalls: results sit in an output register; a stalled m_tready holds it. The
//   next read then waits in the engine with every command behind it queued;
//   votes ahead of it keep running. s_tready stays high until the queue fills.
module hough_line_accumulator_core #(
    parameter int RHO_BINS   = hla_pkg::RHO_BINS_DEF,
    parameter int COUNT_BITS = hla_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [27:20] pixel_value,
    // [35:28] theta_index, [46:36] rho_index, [47] zero
    input  logic [47:0]                         s_tdata,
    // [1:0] kind
    input  logic [hla_pkg::KIND_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [COUNT_BITS-1:0] bin_count, zero filled to whole bytes
    output logic [((COUNT_BITS+7)/8)*8-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [hla_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hla_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hla_pkg::*;

    localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8;

    logic [DIM_W-1:0]      image_width_reg;
    logic [DIM_W-1:0]      image_height_reg;
    logic [OFFSET_W-1:0]   rho_offset_reg;
    logic [VALUE_W-1:0]    edge_level_reg;

    logic                  q_push;
    cmd_t                  q_push_cmd;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    cmd_t                  q_head;
    logic                  clearing;
    logic [COUNT_BITS-1:0] out_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            rho_offset_reg   <= RHO_OFFSET_RST;
            edge_level_reg   <= EDGE_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                CFG_RHO_OFFSET:   rho_offset_reg   <= cfg_data[OFFSET_W-1:0];
                CFG_EDGE_LEVEL:   edge_level_reg   <= cfg_data[VALUE_W-1:0];
                default:          edge_level_reg   <= edge_level_reg;
            endcase
        end
    end

    // decode: items become vote / read / clear commands
    hla_front #(
        .RHO_BINS (RHO_BINS)
    ) u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .edge_level   (edge_level_reg),
        .q_full       (q_full),
        .clearing     (clearing),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd)
    );

    hla_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // vote engine and bin memory
    hla_back #(
        .RHO_BINS   (RHO_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rho_offset (rho_offset_reg),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = OUT_W'(out_data);

endmodule

[test/hough_line_accumulator_core_test.sv]
// Self-checking testbench for hough_line_accumulator_core: drives vote, read, clear and
// unused items on the slave stream and checks every bin count on the master stream.
// Depends on hla_pkg and the core with its submodules hla_front, hla_cmd_fifo and hla_back.
module hough_line_accumulator_core_test;

    import hla_pkg::*;

    localparam int RHO_BINS   = RHO_BINS_DEF;
    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int OUT_W      = ((COUNT_BITS + 7) / 8) * 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [KIND_W-1:0]     KIND_UNUSED = 2'd3;

    // 4-deep queue plus the one in the engine, each a full angle sweep, plus the
    // pipeline drain; a vote can still be running after the last result
    localparam int SETTLE_CYCLES  = 1000;
    // a clear sweep (and the sweep after reset) accepts nothing while it
    // runs; the limit is longer than a sweep
    localparam int WATCHDOG_LIMIT = 1_500_000;
    localparam int PHASE_ITEMS    = 160;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    // [9:0] pixel_x, [19:10] pixel_y, [27:20] pixel_value,
    // [35:28] theta_index, [46:36] rho_index, [47] zero
    logic [47:0]              s_tdata;
    // [1:0] kind
    logic [KIND_W-1:0]        s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    // [20:0] bin_count, [23:21] zero
    logic [OUT_W-1:0]         m_tdata;
    logic                     cfg_we;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    hough_line_accumulator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Accumulator predictor: own trig table, register copies and a sparse
    // copy of the bin memory (absent entry = zero count)
    // ------------------------------------------------------------------
    int                       cos_tab [THETA_STEPS];
    int                       sin_tab [THETA_STEPS];
    logic [DIM_W-1:0]         img_width;
    logic [DIM_W-1:0]         img_height;
    logic [OFFSET_W-1:0]      rho_bias;
    logic [VALUE_W-1:0]       vote_level;
    logic [COUNT_BITS-1:0]    bin_tally [int unsigned];
    int unsigned              voted_bins [$];   // addresses that hold votes
    logic [COUNT_BITS-1:0]    pending_counts [$];

    int src_idle_pct;
    int sink_idle_pct;
    int fail_count;
    int idle_cycles;

    // round(16384 * sin(k deg)), Taylor series in Q30, k in 0..90
    function automatic int q30_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = longint'(k) * PI_Q30 / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        acc  = 0;
        for (int n = 1; n <= 12; n++) begin
            if (n % 2 == 1)
                acc = acc + longint'(term);
            else
                acc = acc - longint'(term);
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        end
        if (acc < 0)
            acc = 0;
        return int'((acc + 32768) >>> 16);
    endfunction

    // one vote per angle, dropped when the rounded distance leaves the grid
    task automatic cast_votes(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        longint      dx;
        longint      dy;
        longint      v;
        longint      rho;
        int unsigned addr;
        dx = longint'(px) - longint'(img_width >> 1);
        dy = longint'(py) - longint'(img_height >> 1);
        for (int t = 0; t < THETA_STEPS; t++) begin
            v = dx * cos_tab[t] + dy * sin_tab[t] + longint'(rho_bias);
            // round half away from zero
            rho = (v >= 0) ? (v + ROUND_HALF) / 16384 : -((-v + ROUND_HALF) / 16384);
            if (rho < 0 || rho >= RHO_BINS)
                continue;
            addr = int'(rho) * THETA_STEPS + t;
            if (!bin_tally.exists(addr)) begin
                bin_tally[addr] = '0;
                voted_bins = {voted_bins, addr};
            end
            if (bin_tally[addr] < COUNT_MAX)
                bin_tally[addr] = bin_tally[addr] + 1'b1;
        end
    endtask

    task automatic predict_item(input logic [KIND_W-1:0] kind,
                                input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                                input logic [VALUE_W-1:0] val,
                                input logic [THETA_W-1:0] th,
                                input logic [RHO_IDX_W-1:0] rh);
        logic [COUNT_BITS-1:0] cnt;
        int unsigned           addr;
        cnt = '0;
        case (kind)
            KIND_VOTE:
                if (val > vote_level)
                    cast_votes(px, py);
            KIND_READ: begin
                // off-grid reads return zero
                if (th < THETA_STEPS && rh < RHO_BINS) begin
                    addr = int'(rh) * THETA_STEPS + int'(th);
                    if (bin_tally.exists(addr))
                        cnt = bin_tally[addr];
                end
                pending_counts = {pending_counts, cnt};
            end
            KIND_CLEAR: begin
                bin_tally.delete();
                voted_bins.delete();
            end
            default: ;  // unused kind: ignored
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Holds tvalid high across back-to-back items; lowers it only for a gap.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                             input logic [VALUE_W-1:0] val,
                             input logic [THETA_W-1:0] th,
                             input logic [RHO_IDX_W-1:0] rh);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, rh, th, val, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(kind, px, py, val, th, rh);
    endtask

    // read fields of a vote carry noise
    task automatic send_vote(input int px, input int py, input int val);
        send_item(KIND_VOTE, PIX_W'(px), PIX_W'(py), VALUE_W'(val),
                  THETA_W'($urandom), RHO_IDX_W'($urandom));
    endtask

    // pixel fields of a read carry noise
    task automatic send_read(input int th, input int rh);
        send_item(KIND_READ, PIX_W'($urandom), PIX_W'($urandom), VALUE_W'($urandom),
                  THETA_W'(th), RHO_IDX_W'(rh));
    endtask

    // read a bin that holds votes, or a random on-grid bin if none does
    task automatic read_voted_bin();
        int unsigned addr;
        if (voted_bins.size() == 0)
            addr = $urandom_range(0, RHO_BINS * THETA_STEPS - 1);
        else
            addr = voted_bins[$urandom_range(0, voted_bins.size() - 1)];
        send_read(addr % THETA_STEPS, addr / THETA_STEPS);
    endtask

    // sender pauses until every bin count is back and the engine is done
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  img_width  = value[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: img_height = value[DIM_W-1:0];
            CFG_RHO_OFFSET:   rho_bias   = value[OFFSET_W-1:0];
            CFG_EDGE_LEVEL:   vote_level = value[VALUE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset registers: edge level 250 is a strict threshold, corner pixels,
    // off-grid reads return zero and an unused kind gives nothing.
    task automatic test_reset_defaults();
        send_vote(0, 0, 255);
        send_vote(1023, 1023, 251);
        send_vote(512, 512, 250);       // at the level: no vote
        send_vote(1023, 0, 0);
        send_item(KIND_UNUSED, '1, '1, '1, '1, '1);
        repeat (4) read_voted_bin();
        send_read(THETA_STEPS, 0);      // angle just off the grid
        send_read(255, RHO_BINS - 1);
        send_read(0, RHO_BINS - 1);
        send_read(THETA_STEPS - 1, 0);
    endtask

    // Register extremes: tiny image with zero offset drops every negative
    // distance; odd sizes and the largest offset push votes past the top bin.
    task automatic test_register_extremes();
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 1);
        cfg_write(CFG_IMAGE_HEIGHT, 1);
        cfg_write(CFG_RHO_OFFSET, 0);
        cfg_write(CFG_EDGE_LEVEL, 0);
        send_vote(0, 0, 1);
        send_vote(1023, 1023, 1);       // far outside the image
        send_vote(0, 1023, 0);          // value equal to level: no vote
        repeat (3) read_voted_bin();

        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 0);
        cfg_write(CFG_IMAGE_HEIGHT, 2047);
        cfg_write(CFG_RHO_OFFSET, 25'h1FF_FFFF);
        cfg_write(CFG_EDGE_LEVEL, 255);
        send_vote(511, 0, 255);         // nothing exceeds 255
        wait_idle();
        cfg_write(CFG_EDGE_LEVEL, 254);
        send_vote(1023, 1023, 255);
        send_vote(0, 0, 255);
        repeat (3) read_voted_bin();
    endtask

    // Clear zeroes the whole memory; it holds tready low for the full sweep.
    task automatic test_clear();
        int unsigned old_bins [$];
        wait_idle();
        old_bins = voted_bins;
        send_item(KIND_CLEAR, '0, '0, '0, '0, '0);
        for (int i = 0; i < 3 && i < old_bins.size(); i++)
            send_read(old_bins[i] % THETA_STEPS, old_bins[i] / THETA_STEPS);
        send_vote(300, 700, 255);
        read_voted_bin();
    endtask

    // Random items under one register setting and one idling pattern.
    task automatic test_random_phase(input int src_pct, input int sink_pct,
                                     input bit wild_offset);
        int w;
        int h;
        int val;
        int n_sent;
        int pick;
        wait_idle();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        w = $urandom_range(1, 1024);
        h = $urandom_range(1, 1024);
        cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        // a sane offset is about sqrt2 * larger side / 2 in Q14
        if (wild_offset)
            cfg_write(CFG_RHO_OFFSET, CFG_DATA_W'($urandom_range(0, 33554431)));
        else
            cfg_write(CFG_RHO_OFFSET,
                      CFG_DATA_W'(((w > h) ? w : h) * 11585 + $urandom_range(0, 16383)));
        cfg_write(CFG_EDGE_LEVEL, CFG_DATA_W'($urandom_range(0, 200)));

        n_sent = 0;
        while (n_sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                val = $urandom_range(0, 255);
                if ($urandom_range(0, 99) < 80)
                    send_vote($urandom_range(0, w - 1), $urandom_range(0, h - 1), val);
                else
                    send_vote($urandom_range(0, 1023), $urandom_range(0, 1023), val);
            end else if (pick < 93) begin
                if ($urandom_range(0, 99) < 75)
                    read_voted_bin();
                else
                    send_read($urandom_range(0, 255), $urandom_range(0, 2047));
            end else begin
                send_item(KIND_UNUSED, PIX_W'($urandom), PIX_W'($urandom),
                          VALUE_W'($urandom), THETA_W'($urandom), RHO_IDX_W'($urandom));
            end
            n_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the oldest expected count
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] want_count;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("unexpected bin count %0d", m_tdata));
            end else begin
                want_count = pending_counts.pop_front();
                if (m_tdata !== OUT_W'(want_count))
                    report_mismatch($sformatf("bin_count %0d, expected %0d",
                                              m_tdata, want_count));
            end
        end
    end

    // receiver stalls at the current idle rate
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // watchdog: cycles without any handshake on either stream
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_VOTE;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= '0;
        idle_cycles   = 0;
        fail_count    = 0;
        src_idle_pct  = 14;
        sink_idle_pct = 68;

        for (int t = 0; t < THETA_STEPS; t++) begin
            if (t <= 90) begin
                cos_tab[t] = q30_sine(90 - t);
                sin_tab[t] = q30_sine(t);
            end else begin
                cos_tab[t] = -q30_sine(t - 90);
                sin_tab[t] = q30_sine(180 - t);
            end
        end
        img_width  = IMAGE_WIDTH_RST;
        img_height = IMAGE_HEIGHT_RST;
        rho_bias   = RHO_OFFSET_RST;
        vote_level = EDGE_LEVEL_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the first item waits out the clearing sweep after reset
        test_reset_defaults();
        test_register_extremes();
        test_clear();
        test_random_phase(14, 68, 1'b0);
        test_random_phase(68, 14, 1'b1);
        test_random_phase(0, 0, 1'b0);

        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
